[hdl/ecss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecss_pkg
// Opcodes, source codes, civil calendar constants and the reset slot length for the epoch clock.
// ----------------------------------------------------------------------------
package ecss_pkg;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_EPOCH = 3'd1,
        OP_CIVIL = 3'd2,
        OP_SHIFT = 3'd3,
        OP_ALIGN = 3'd4,
        OP_TOD   = 3'd5,
        OP_TRIM  = 3'd6
    } op_t;

    localparam logic [2:0]  SRC_NONE   = 3'd0;
    localparam logic [2:0]  SRC_MANUAL = 3'd1;
    localparam logic [26:0] MS_PER_DAY = 27'd86400000;
    localparam logic [15:0] SLOT_RESET = 16'd15000;

    // day of year at the first of a march-based month
    function automatic logic [10:0] month_base(input logic [3:0] m);
        logic [10:0] r;
        case (m)
            4'd0:    r = 11'd275;
            4'd1:    r = 11'd306;
            4'd2:    r = 11'd337;
            4'd3:    r = 11'd0;
            4'd4:    r = 11'd31;
            4'd5:    r = 11'd61;
            4'd6:    r = 11'd92;
            4'd7:    r = 11'd122;
            4'd8:    r = 11'd153;
            4'd9:    r = 11'd184;
            4'd10:   r = 11'd214;
            4'd11:   r = 11'd245;
            4'd12:   r = 11'd275;
            4'd13:   r = 11'd306;
            4'd14:   r = 11'd337;
            4'd15:   r = 11'd367;
            default: r = 11'd0;
        endcase
        return r;
    endfunction

endpackage

[hdl/epoch_clock_with_slot_sync.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_clock_with_slot_sync
// Millisecond epoch clock with sync tracking and slot start reporting.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: s_tuser carries the opcode, s_tdata
// the operands. Each item yields one status item on the m_ stream.
// The slot length register is written through cfg_we / cfg_wdata; the user
// must write it only while idle; the block itself does not enforce this.
// One item is worked at a time. A bit-serial restoring divider produces one
// remainder bit per cycle. Tick, set, shift, trim and the unused opcode
// divide once, for the slot start; a civil set runs its calendar steps
// before that division; slot align and time of day divide twice. s_tready
// rises again with m_tvalid.
// s_tready is high while no item is in work; a status item waiting in the
// output register does not block acceptance, only the final hand-over.
// When the receiver stalls, m_tdata holds and the next item waits at its
// last step until the output register is free.
// Reset (aresetn low, synchronous) clears the clock, source, count and jump,
// sets the slot length to 15000 ms and drops m_tvalid.
// ----------------------------------------------------------------------------
module epoch_clock_with_slot_sync #(
    parameter int TIME_BITS = 47
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [15:0]              cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // opcode
    input  logic [2:0]               s_tuser,
    // target_ms, delta_ms, year, month, day, hour, minute, second, source
    input  logic [((TIME_BITS + 73 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // now_ms, slot_start_ms, current_source, synced, sync_events, last_jump_ms
    output logic [((2 * TIME_BITS + 68 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W = ((2 * TIME_BITS + 68 + 7) / 8) * 8;
    localparam int TB    = TIME_BITS;
    localparam int CW    = $clog2(TIME_BITS + 1);
    localparam int W     = ((TIME_BITS > 52) ? TIME_BITS : 52) + 2;
    localparam logic [TB-1:0] MAX_T = {TB{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_CIV0, ST_CIV1, ST_CIV2, ST_CIV3, ST_CIV4, ST_CHK,
        ST_DIV, ST_POST, ST_COMMIT, ST_FIN
    } state_t;

    function automatic logic [TB-1:0] sat_add(input logic [TB-1:0] base,
                                              input logic signed [32:0] d);
        logic signed [TB+1:0] sum;
        sum = $signed({2'b00, base}) + (TB+2)'(d);
        if (sum < 0)
            return '0;
        else if (sum > $signed({2'b00, MAX_T}))
            return MAX_T;
        else
            return sum[TB-1:0];
    endfunction

    state_t               state_reg, state_next;
    logic [15:0]          slot_reg, slot_next;
    logic [TB-1:0]        clock_reg, clock_next;
    logic [2:0]           src_reg, src_next;
    logic [31:0]          count_reg, count_next;
    logic signed [31:0]   jump_reg, jump_next;

    ecss_pkg::op_t        op_reg, op_next;
    logic [TB-1:0]        target_reg, target_next;
    logic signed [31:0]   delta_reg, delta_next;
    logic [11:0]          year_reg, year_next;
    logic [3:0]           month_reg, month_next;
    logic [4:0]           day_reg, day_next;
    logic [4:0]           hour_reg, hour_next;
    logic [5:0]           minute_reg, minute_next;
    logic [5:0]           second_reg, second_next;
    logic [2:0]           source_reg, source_next;

    logic [TB-1:0]        new_reg, new_next;
    logic                 sync_reg, sync_next;
    logic [2:0]           nsrc_reg, nsrc_next;
    logic                 slotpass_reg, slotpass_next;
    logic [TB-1:0]        base_reg, base_next;
    logic [TB-1:0]        num_reg, num_next;
    logic [26:0]          rem_reg, rem_next;
    logic [26:0]          div_reg, div_next;
    logic [CW-1:0]        cnt_reg, cnt_next;

    logic [16:0]          hms_reg, hms_next;
    logic signed [12:0]   y_reg, y_next;
    logic signed [4:0]    era_reg, era_next;
    logic [8:0]           yoe_reg, yoe_next;
    logic signed [11:0]   doy_reg, doy_next;
    logic signed [23:0]   days_reg, days_next;
    logic signed [41:0]   ts_reg, ts_next;
    logic signed [51:0]   tsms_reg, tsms_next;

    logic                 ov_reg, ov_next;
    logic [TB-1:0]        onow_reg, onow_next;
    logic [TB-1:0]        oslot_reg, oslot_next;
    logic [2:0]           osrc_reg, osrc_next;
    logic [31:0]          ocnt_reg, ocnt_next;
    logic [31:0]          ojump_reg, ojump_next;

    logic [15:0]          len;
    logic [14:0]          half;
    logic [27:0]          r2;
    logic                 ge;
    logic [24:0]          era_prod;
    logic signed [12:0]   yoe_w;
    logic [18:0]          yoe365;
    logic [15:0]          q100;
    logic [18:0]          doe_u;
    logic signed [18:0]   doe;
    logic signed [W-1:0]  clk_w, ts_w, ts_hi, max_w;
    logic signed [TB:0]   diff;
    logic [TB-1:0]        rem_t, tbase;
    logic [26:0]          tod;

    assign len  = (slot_reg == 16'd0) ? 16'd1 : slot_reg;
    assign half = len[15:1];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = OUT_W'({ojump_reg, ocnt_reg, (osrc_reg != 3'd0), osrc_reg,
                              oslot_reg, onow_reg});

    always_comb begin
        state_next    = state_reg;
        slot_next     = cfg_we ? cfg_wdata : slot_reg;
        clock_next    = clock_reg;
        src_next      = src_reg;
        count_next    = count_reg;
        jump_next     = jump_reg;
        op_next       = op_reg;
        target_next   = target_reg;
        delta_next    = delta_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        source_next   = source_reg;
        new_next      = new_reg;
        sync_next     = sync_reg;
        nsrc_next     = nsrc_reg;
        slotpass_next = slotpass_reg;
        base_next     = base_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        hms_next      = hms_reg;
        y_next        = y_reg;
        era_next      = era_reg;
        yoe_next      = yoe_reg;
        doy_next      = doy_reg;
        days_next     = days_reg;
        ts_next       = ts_reg;
        tsms_next     = tsms_reg;
        ov_next       = (ov_reg && m_tready) ? 1'b0 : ov_reg;
        onow_next     = onow_reg;
        oslot_next    = oslot_reg;
        osrc_next     = osrc_reg;
        ocnt_next     = ocnt_reg;
        ojump_next    = ojump_reg;

        r2       = {rem_reg, num_reg[TB-1]};
        ge       = (r2 >= {1'b0, div_reg});
        era_prod = {13'd0, y_reg[11:0]} * 25'd5243;
        yoe_w    = y_reg - 13'(era_reg) * 13'sd400;
        yoe365   = 19'(yoe_reg) * 19'd365;
        q100     = (16'(yoe_reg) * 16'd41) >> 12;
        doe_u    = yoe365 + 19'(yoe_reg[8:2]) - 19'(q100);
        doe      = $signed(doe_u) + 19'(doy_reg);
        clk_w    = W'(clock_reg);
        ts_w     = W'(tsms_reg);
        ts_hi    = ts_w + W'(999);
        max_w    = W'(MAX_T);
        diff     = $signed({1'b0, new_reg}) - $signed({1'b0, clock_reg});
        rem_t    = TB'(rem_reg);
        tbase    = clock_reg - rem_t;
        tod      = 27'(hms_reg) * 27'd1000;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next     = ecss_pkg::op_t'(s_tuser);
                    target_next = s_tdata[TB-1:0];
                    delta_next  = s_tdata[TB+31:TB];
                    year_next   = s_tdata[TB+43:TB+32];
                    month_next  = s_tdata[TB+47:TB+44];
                    day_next    = s_tdata[TB+52:TB+48];
                    hour_next   = s_tdata[TB+57:TB+53];
                    minute_next = s_tdata[TB+63:TB+58];
                    second_next = s_tdata[TB+69:TB+64];
                    source_next = s_tdata[TB+72:TB+70];
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                hms_next      = 17'(hour_reg) * 17'd3600 + 17'(minute_reg) * 17'd60
                                + 17'(second_reg);
                sync_next     = 1'b0;
                nsrc_next     = source_reg;
                new_next      = clock_reg;
                slotpass_next = 1'b0;
                state_next    = ST_COMMIT;
                case (op_reg)
                    ecss_pkg::OP_TICK:  new_next = sat_add(clock_reg, 33'sd1);
                    ecss_pkg::OP_EPOCH: begin
                        new_next  = target_reg;
                        sync_next = 1'b1;
                    end
                    ecss_pkg::OP_CIVIL: state_next = ST_CIV0;
                    ecss_pkg::OP_SHIFT: begin
                        new_next  = sat_add(clock_reg, 33'(delta_reg));
                        sync_next = 1'b1;
                    end
                    ecss_pkg::OP_ALIGN: begin
                        num_next   = clock_reg;
                        rem_next   = '0;
                        div_next   = 27'(len);
                        cnt_next   = CW'(TIME_BITS);
                        state_next = ST_DIV;
                    end
                    ecss_pkg::OP_TOD: begin
                        num_next   = clock_reg;
                        rem_next   = '0;
                        div_next   = ecss_pkg::MS_PER_DAY;
                        cnt_next   = CW'(TIME_BITS);
                        state_next = ST_DIV;
                    end
                    ecss_pkg::OP_TRIM:  new_next = sat_add(clock_reg, 33'(delta_reg));
                    default:            new_next = clock_reg;
                endcase
            end
            ST_CIV0: begin
                y_next     = $signed({1'b0, year_reg}) - ((month_reg <= 4'd2) ? 13'sd1 : 13'sd0);
                state_next = ST_CIV1;
            end
            ST_CIV1: begin
                era_next   = y_reg[12] ? -5'sd1 : $signed({1'b0, era_prod[24:21]});
                doy_next   = $signed({1'b0, ecss_pkg::month_base(month_reg)})
                             + $signed({7'd0, day_reg}) - 12'sd1;
                state_next = ST_CIV2;
            end
            ST_CIV2: begin
                yoe_next   = yoe_w[8:0];
                state_next = ST_CIV3;
            end
            ST_CIV3: begin
                days_next  = 24'(era_reg) * 24'sd146097 + 24'(doe) - 24'sd719468;
                state_next = ST_CIV4;
            end
            ST_CIV4: begin
                ts_next    = 42'(days_reg) * 42'sd86400 + 42'(hms_reg);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (!cnt_reg[0]) begin
                    tsms_next = 52'(ts_reg) * 52'sd1000;
                    cnt_next  = CW'(1);
                end else begin
                    cnt_next   = '0;
                    state_next = ST_COMMIT;
                    if (src_reg != ecss_pkg::SRC_NONE && !tsms_reg[51] &&
                        clk_w >= ts_w && clk_w <= ts_hi) begin
                        src_next  = source_reg;
                        sync_next = 1'b0;
                        new_next  = clock_reg;
                    end else begin
                        sync_next = 1'b1;
                        if (tsms_reg[51])
                            new_next = '0;
                        else if (ts_w > max_w)
                            new_next = MAX_T;
                        else
                            new_next = ts_w[TB-1:0];
                    end
                end
            end
            ST_DIV: begin
                rem_next = ge ? 27'(r2 - {1'b0, div_reg}) : r2[26:0];
                num_next = num_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = slotpass_reg ? ST_FIN : ST_POST;
            end
            ST_POST: begin
                sync_next  = 1'b1;
                nsrc_next  = ecss_pkg::SRC_MANUAL;
                state_next = ST_COMMIT;
                if (op_reg == ecss_pkg::OP_ALIGN)
                    new_next = (rem_reg >= 27'(half)) ? sat_add(tbase, 33'(len)) : tbase;
                else
                    new_next = sat_add(tbase, 33'(tod));
            end
            ST_COMMIT: begin
                clock_next = new_reg;
                if (sync_reg) begin
                    src_next   = nsrc_reg;
                    count_next = count_reg + 32'd1;
                    if (diff > (TB+1)'(33'sd2147483647))
                        jump_next = 32'sh7fffffff;
                    else if (diff < (TB+1)'(-33'sd2147483648))
                        jump_next = 32'sh80000000;
                    else
                        jump_next = diff[31:0];
                end
                base_next     = (new_reg > TB'(half)) ? new_reg - TB'(half) : '0;
                num_next      = (new_reg > TB'(half)) ? new_reg - TB'(half) : '0;
                rem_next      = '0;
                div_next      = 27'(len);
                cnt_next      = CW'(TIME_BITS);
                slotpass_next = 1'b1;
                state_next    = ST_DIV;
            end
            ST_FIN: begin
                if (!ov_reg || m_tready) begin
                    ov_next    = 1'b1;
                    onow_next  = clock_reg;
                    oslot_next = base_reg - rem_t;
                    osrc_next  = src_reg;
                    ocnt_next  = count_reg;
                    ojump_next = jump_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= ecss_pkg::SLOT_RESET;
            clock_reg    <= '0;
            src_reg      <= ecss_pkg::SRC_NONE;
            count_reg    <= '0;
            jump_reg     <= '0;
            ov_reg       <= 1'b0;
            cnt_reg      <= '0;
            sync_reg     <= 1'b0;
            slotpass_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            clock_reg    <= clock_next;
            src_reg      <= src_next;
            count_reg    <= count_next;
            jump_reg     <= jump_next;
            ov_reg       <= ov_next;
            cnt_reg      <= cnt_next;
            sync_reg     <= sync_next;
            slotpass_reg <= slotpass_next;
        end
        op_reg     <= op_next;
        target_reg <= target_next;
        delta_reg  <= delta_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        source_reg <= source_next;
        new_reg    <= new_next;
        nsrc_reg   <= nsrc_next;
        base_reg   <= base_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        hms_reg    <= hms_next;
        y_reg      <= y_next;
        era_reg    <= era_next;
        yoe_reg    <= yoe_next;
        doy_reg    <= doy_next;
        days_reg   <= days_next;
        ts_reg     <= ts_next;
        tsms_reg   <= tsms_next;
        onow_reg   <= onow_next;
        oslot_reg  <= oslot_next;
        osrc_reg   <= osrc_next;
        ocnt_reg   <= ocnt_next;
        ojump_reg  <= ojump_next;
    end

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in work");

    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    a_synced_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2*TB+3] == (m_tdata[2*TB+2:2*TB] != 3'd0)))
        else $error("synced flag disagrees with source");

    a_slot_le_now: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (oslot_reg <= onow_reg))
        else $error("slot start after clock value");

endmodule

[sim/epoch_clock_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_clock_checker
// Watches both streams of the epoch clock, keeps its own copy of the clock,
// sync source, sync count, last jump and slot length, predicts the status item
// for every accepted input item and compares each status item field by field.
// ----------------------------------------------------------------------------
module epoch_clock_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [2:0]   s_tuser,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [167:0] m_tdata,
    output int           errors,
    output int           pending
);

    localparam longint CLOCK_MAX = (64'sd1 <<< 47) - 1;

    typedef struct packed {
        logic [31:0] last_jump;
        logic [31:0] sync_events;
        logic        synced;
        logic [2:0]  source;
        logic [46:0] slot_start;
        logic [46:0] now_ms;
    } status_t;

    status_t     status_q[$];
    longint      clock_ms;
    logic [2:0]  sync_src;
    logic [31:0] sync_cnt;
    logic [31:0] jump_ms;
    longint      slot_len;

    initial begin
        errors = 0;
        pending = 0;
    end

    function automatic longint clamp_clock(input longint v);
        if (v < 0) return 0;
        if (v > CLOCK_MAX) return CLOCK_MAX;
        return v;
    endfunction

    function automatic longint civil_to_days(input longint y, input longint m,
                                             input longint d);
        longint era, yoe, doy, doe;
        if (m <= 2) y = y - 1;
        era = (y >= 0 ? y : y - 399) / 400;
        yoe = y - era * 400;
        doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        return era * 146097 + doe - 719468;
    endfunction

    task automatic take_sync(input longint target, input logic [2:0] src);
        longint diff;
        diff = target - clock_ms;
        if (diff > 64'sd2147483647)
            jump_ms = 32'h7fff_ffff;
        else if (diff < -64'sd2147483648)
            jump_ms = 32'h8000_0000;
        else
            jump_ms = diff[31:0];
        clock_ms = target;
        sync_src = src;
        sync_cnt = sync_cnt + 1;
    endtask

    task automatic apply_item(input logic [2:0] op, input logic [119:0] d);
        longint target, offset, yr, mo, dy, hr, mi, se, ts, len, half, rem, t, s;
        logic [2:0] src;
        status_t st;
        target = longint'(d[46:0]);
        offset = longint'($signed(d[78:47]));
        yr = longint'(d[90:79]);
        mo = longint'(d[94:91]);
        dy = longint'(d[99:95]);
        hr = longint'(d[104:100]);
        mi = longint'(d[110:105]);
        se = longint'(d[116:111]);
        src = d[119:117];
        len = (slot_len == 0) ? 1 : slot_len;
        half = len / 2;
        case (op)
            ecss_pkg::OP_TICK:  clock_ms = clamp_clock(clock_ms + 1);
            ecss_pkg::OP_EPOCH: take_sync(clamp_clock(target), src);
            ecss_pkg::OP_CIVIL: begin
                ts = civil_to_days(yr, mo, dy) * 86400 + hr * 3600 + mi * 60 + se;
                if (sync_src != ecss_pkg::SRC_NONE && clock_ms / 1000 == ts)
                    sync_src = src;
                else
                    take_sync(clamp_clock(ts * 1000), src);
            end
            ecss_pkg::OP_SHIFT: take_sync(clamp_clock(clock_ms + offset), src);
            ecss_pkg::OP_ALIGN: begin
                rem = clock_ms % len;
                t = clock_ms - rem;
                if (rem >= half) t = clamp_clock(t + len);
                take_sync(t, ecss_pkg::SRC_MANUAL);
            end
            ecss_pkg::OP_TOD: begin
                t = clock_ms - clock_ms % longint'(ecss_pkg::MS_PER_DAY);
                take_sync(clamp_clock(t + (hr * 3600 + mi * 60 + se) * 1000),
                          ecss_pkg::SRC_MANUAL);
            end
            ecss_pkg::OP_TRIM: clock_ms = clamp_clock(clock_ms + offset);
            default: ;
        endcase
        s = (clock_ms > half) ? clock_ms - half : 0;
        s = s - s % len;
        st.now_ms = clock_ms[46:0];
        st.slot_start = s[46:0];
        st.source = sync_src;
        st.synced = (sync_src != ecss_pkg::SRC_NONE);
        st.sync_events = sync_cnt;
        st.last_jump = jump_ms;
        status_q.push_back(st);
    endtask

    task automatic check_status(input status_t act);
        status_t exp;
        if (status_q.size() == 0) begin
            $display("%0t: status item with none expected: %h", $time, act);
            errors++;
            return;
        end
        exp = status_q.pop_front();
        if (act.now_ms !== exp.now_ms) begin
            $display("%0t: now_ms exp %0d act %0d", $time, exp.now_ms, act.now_ms);
            errors++;
        end
        if (act.slot_start !== exp.slot_start) begin
            $display("%0t: slot_start_ms exp %0d act %0d", $time, exp.slot_start,
                     act.slot_start);
            errors++;
        end
        if (act.source !== exp.source) begin
            $display("%0t: current_source exp %0d act %0d", $time, exp.source, act.source);
            errors++;
        end
        if (act.synced !== exp.synced) begin
            $display("%0t: synced exp %0d act %0d", $time, exp.synced, act.synced);
            errors++;
        end
        if (act.sync_events !== exp.sync_events) begin
            $display("%0t: sync_events exp %0d act %0d", $time, exp.sync_events,
                     act.sync_events);
            errors++;
        end
        if (act.last_jump !== exp.last_jump) begin
            $display("%0t: last_jump_ms exp %0d act %0d", $time, $signed(exp.last_jump),
                     $signed(act.last_jump));
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clock_ms = 0;
            sync_src = ecss_pkg::SRC_NONE;
            sync_cnt = 0;
            jump_ms = 0;
            slot_len = longint'(ecss_pkg::SLOT_RESET);
            status_q.delete();
        end else begin
            if (cfg_we) slot_len = longint'(cfg_wdata);
            if (m_tvalid && m_tready) check_status(status_t'(m_tdata[161:0]));
            if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
        end
        pending <= status_q.size();
    end

endmodule

[sim/tb_epoch_clock_with_slot_sync.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_clock_with_slot_sync
// Drives the epoch clock with directed items at the limits of every opcode,
// then random items under several slot lengths and idling patterns, with a
// long receiver hold-off; the checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_epoch_clock_with_slot_sync;

    localparam logic [2:0]  OP_UNUSED = 3'd7;
    localparam logic [46:0] CLOCK_TOP = '1;
    localparam int          WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        logic [2:0]  source;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic [31:0] delta;
        logic [46:0] target;
    } operands_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [15:0]  cfg_wdata = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [2:0]   s_tuser = 0;
    logic [119:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [167:0] m_tdata;
    int           errors, pending;
    int           send_idle_pct = 0, recv_idle_pct = 0;
    int           hold_cycles = 0;
    bit           hold_start = 0;
    bit           hold_done = 0;
    int           quiet_cycles = 0;
    operands_t    last_civil;
    bit           have_civil = 0;
    logic [15:0]  slot_settings[6] = '{16'd60000, 16'd0, 16'd1000, 16'd65535,
                                       16'd1, 16'd15000};

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    epoch_clock_with_slot_sync dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    epoch_clock_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .errors(errors), .pending(pending)
    );

    // receiver with random stalls and a counted hold-off
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 0;
        else if (hold_start && !hold_done) begin
            m_tready <= 0;
            hold_cycles <= 400;
            hold_done <= 1;
        end else if (hold_cycles != 0) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_epoch_clock_with_slot_sync: FAIL");
            $finish;
        end
    end

    function automatic operands_t random_operands();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return operands_t'(r[119:0]);
    endfunction

    task automatic send_item(input logic [2:0] op, input operands_t f);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
        s_tuser <= op;
        s_tdata <= f;
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_op(input logic [2:0] op, input logic [46:0] target,
                           input logic [31:0] delta, input logic [2:0] src);
        operands_t f;
        f = random_operands();
        f.target = target;
        f.delta = delta;
        f.source = src;
        send_item(op, f);
    endtask

    task automatic send_civil(input logic [2:0] op, input logic [11:0] y,
                              input logic [3:0] mo, input logic [4:0] d,
                              input logic [4:0] h, input logic [5:0] mi,
                              input logic [5:0] s, input logic [2:0] src);
        operands_t f;
        f = random_operands();
        f.year = y;
        f.month = mo;
        f.day = d;
        f.hour = h;
        f.minute = mi;
        f.second = s;
        f.source = src;
        send_item(op, f);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_slot_length(input logic [15:0] v);
        drain();
        cfg_wdata <= v;
        cfg_we <= 1;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic random_item();
        operands_t f;
        int pick;
        logic [2:0] op;
        f = random_operands();
        pick = $urandom_range(99);
        if ($urandom_range(99) < 85) f.source = 3'($urandom_range(4));
        if (pick < 40)
            op = ecss_pkg::OP_TICK;
        else if (pick < 48) begin
            op = ecss_pkg::OP_EPOCH;
            pick = $urandom_range(9);
            if (pick < 8) f.target = {6'd0, f.target[40:0]};
            else if (pick == 8) f.target = CLOCK_TOP - 47'($urandom_range(100000));
        end else if (pick < 63) begin
            op = ecss_pkg::OP_CIVIL;
            if (have_civil && $urandom_range(2) == 0) begin
                f.year = last_civil.year;
                f.month = last_civil.month;
                f.day = last_civil.day;
                f.hour = last_civil.hour;
                f.minute = last_civil.minute;
                f.second = last_civil.second;
            end else if ($urandom_range(9) != 0) begin
                f.year = 12'($urandom_range(1970, 4095));
                f.month = 4'($urandom_range(1, 12));
                f.day = 5'($urandom_range(1, 31));
                f.hour = 5'($urandom_range(23));
                f.minute = 6'($urandom_range(59));
                f.second = 6'($urandom_range(59));
            end
            last_civil = f;
            have_civil = 1;
        end else if (pick < 71) begin
            op = ecss_pkg::OP_SHIFT;
            if ($urandom_range(9) < 7) f.delta = $urandom_range(200000) - 100000;
        end else if (pick < 77)
            op = ecss_pkg::OP_ALIGN;
        else if (pick < 85) begin
            op = ecss_pkg::OP_TOD;
            if ($urandom_range(9) != 0) begin
                f.hour = 5'($urandom_range(23));
                f.minute = 6'($urandom_range(59));
                f.second = 6'($urandom_range(59));
            end
        end else if (pick < 97) begin
            op = ecss_pkg::OP_TRIM;
            if ($urandom_range(9) < 7) f.delta = $urandom_range(200000) - 100000;
        end else
            op = OP_UNUSED;
        send_item(op, f);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        send_idle_pct = 20;
        recv_idle_pct = 65;

        // limits and special cases at reset slot length
        send_op(ecss_pkg::OP_TICK, '0, '0, '0);
        send_op(ecss_pkg::OP_TRIM, '0, 32'hffff_ffff, '0);
        send_op(ecss_pkg::OP_EPOCH, CLOCK_TOP, '0, 3'd2);
        send_op(ecss_pkg::OP_TICK, '0, '0, '0);
        send_op(ecss_pkg::OP_SHIFT, '0, 32'h7fff_ffff, 3'd3);
        send_op(ecss_pkg::OP_ALIGN, '0, '0, '0);
        send_op(ecss_pkg::OP_EPOCH, '0, '0, 3'd7);
        send_civil(ecss_pkg::OP_CIVIL, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3);
        send_civil(ecss_pkg::OP_CIVIL, 12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd4);
        send_civil(ecss_pkg::OP_CIVIL, 12'd2024, 4'd2, 5'd29, 5'd12, 6'd34, 6'd56, 3'd2);
        send_op(ecss_pkg::OP_TICK, '0, '0, '0);
        send_civil(ecss_pkg::OP_CIVIL, 12'd2024, 4'd2, 5'd29, 5'd12, 6'd34, 6'd56, 3'd1);
        send_civil(ecss_pkg::OP_CIVIL, 12'd0, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63, 3'd5);
        send_civil(ecss_pkg::OP_CIVIL, 12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 3'd6);
        send_civil(ecss_pkg::OP_TOD, 12'd0, 4'd0, 5'd0, 5'd23, 6'd59, 6'd59, 3'd0);
        send_civil(ecss_pkg::OP_TOD, 12'd0, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63, 3'd0);
        send_op(ecss_pkg::OP_SHIFT, '0, 32'h8000_0000, 3'd1);
        send_op(ecss_pkg::OP_TRIM, '0, 32'h7fff_ffff, '0);
        send_op(ecss_pkg::OP_TRIM, '0, 32'h8000_0000, '0);
        send_op(ecss_pkg::OP_EPOCH, 47'd7500, '0, 3'd4);
        send_op(ecss_pkg::OP_ALIGN, '0, '0, '0);
        send_op(ecss_pkg::OP_EPOCH, 47'd7499, '0, 3'd4);
        send_op(ecss_pkg::OP_ALIGN, '0, '0, '0);
        send_op(OP_UNUSED, '0, '0, '0);

        for (int i = 0; i < 1650; i++) begin
            if (i == 550) begin
                send_idle_pct = 65;
                recv_idle_pct = 20;
            end
            if (i == 1100) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i % 275 == 0) write_slot_length(slot_settings[i / 275]);
            if (i == 1200) hold_start = 1;
            random_item();
        end
        drain();

        if (errors == 0 && pending == 0)
            $display("tb_epoch_clock_with_slot_sync: PASS");
        else
            $display("tb_epoch_clock_with_slot_sync: FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/ecss_pkg.sv
hdl/epoch_clock_with_slot_sync.sv
sim/epoch_clock_checker.sv
sim/tb_epoch_clock_with_slot_sync.sv
